@@ design/aps_pkg.sv @@
// Shared types and constants of the assignment problem solver.
// Used by the controller, the datapath, the top level and the checker.
package aps_pkg;

  localparam int MAX_SIZE_DEF = 32;
  localparam int COST_W_DEF   = 16;
  localparam int CELL_W       = 24;
  localparam int CFG_W        = 6;
  localparam int IDX_OUT_W    = 5;
  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_ROW_MIN,
    OP_ROW_SUB,
    OP_COL_MIN,
    OP_COL_SUB,
    OP_ZCOUNT,
    OP_BEST,
    OP_GFIND,
    OP_GDEC,
    OP_COVER,
    OP_FIND,
    OP_PRIME,
    OP_AUG,
    OP_SMIN,
    OP_SHIFT,
    OP_EMIT
  } dp_op_e;

  // Cell walk orders
  typedef enum logic [1:0] {
    SK_ROW,
    SK_COL,
    SK_ALL
  } sweep_kind_e;

  // Controller states
  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_RMIN,
    S_RSUB,
    S_CMIN,
    S_CSUB,
    S_ZCNT,
    S_BEST,
    S_GFIND,
    S_GDEC,
    S_COVER,
    S_CHECK,
    S_FIND,
    S_PRIME,
    S_AUG,
    S_SMIN,
    S_SHIFT,
    S_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   start;
    logic   load_we;
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;
    logic sweep_done;
    logic line_last;
    logic found;
    logic hit;
    logic any;
    logic sir_hit;
    logic aug_more;
    logic all_cov;
    logic emit_busy;
  } dp_stat_t;

endpackage

@@ design/aps_ctrl.sv @@
// Sequencing state machine of the assignment problem solver.
// Depends on aps_pkg; drives datapath commands and the input stall.
module aps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  aps_pkg::dp_stat_t stat_i,
  output aps_pkg::dp_cmd_t  cmd_o,
  output logic              in_stall_o
);

  aps_pkg::ctl_state_e state_q, state_d;
  logic issued_q, issued_d;
  logic sweep_st, single_st, accept;

  // Decode command for the current state
  always_comb begin
    cmd_o.op  = aps_pkg::OP_NONE;
    sweep_st  = 1'b0;
    single_st = 1'b0;
    case (state_q)
      aps_pkg::S_START: begin cmd_o.op = aps_pkg::OP_START;   single_st = 1'b1; end
      aps_pkg::S_RMIN:  begin cmd_o.op = aps_pkg::OP_ROW_MIN; sweep_st  = 1'b1; end
      aps_pkg::S_RSUB:  begin cmd_o.op = aps_pkg::OP_ROW_SUB; sweep_st  = 1'b1; end
      aps_pkg::S_CMIN:  begin cmd_o.op = aps_pkg::OP_COL_MIN; sweep_st  = 1'b1; end
      aps_pkg::S_CSUB:  begin cmd_o.op = aps_pkg::OP_COL_SUB; sweep_st  = 1'b1; end
      aps_pkg::S_ZCNT:  begin cmd_o.op = aps_pkg::OP_ZCOUNT;  sweep_st  = 1'b1; end
      aps_pkg::S_BEST:  begin cmd_o.op = aps_pkg::OP_BEST;    sweep_st  = 1'b1; end
      aps_pkg::S_GFIND: begin cmd_o.op = aps_pkg::OP_GFIND;   sweep_st  = 1'b1; end
      aps_pkg::S_GDEC:  begin cmd_o.op = aps_pkg::OP_GDEC;    sweep_st  = 1'b1; end
      aps_pkg::S_COVER: begin cmd_o.op = aps_pkg::OP_COVER;   single_st = 1'b1; end
      aps_pkg::S_FIND:  begin cmd_o.op = aps_pkg::OP_FIND;    sweep_st  = 1'b1; end
      aps_pkg::S_PRIME: begin cmd_o.op = aps_pkg::OP_PRIME;   single_st = 1'b1; end
      aps_pkg::S_AUG:   begin cmd_o.op = aps_pkg::OP_AUG;     single_st = 1'b1; end
      aps_pkg::S_SMIN:  begin cmd_o.op = aps_pkg::OP_SMIN;    sweep_st  = 1'b1; end
      aps_pkg::S_SHIFT: begin cmd_o.op = aps_pkg::OP_SHIFT;   sweep_st  = 1'b1; end
      aps_pkg::S_EMIT:  begin cmd_o.op = aps_pkg::OP_EMIT;    single_st = 1'b1; end
      default: ;
    endcase
    cmd_o.start   = sweep_st ? !issued_q : single_st;
    // hold the completing word while the previous results still drain
    in_stall_o    = (state_q != aps_pkg::S_LOAD) || (stat_i.load_last && stat_i.emit_busy);
    accept        = in_valid_i && !in_stall_o;
    cmd_o.load_we = accept;
  end

  // Track that a sweep was launched
  always_comb begin
    issued_d = issued_q;
    if (stat_i.sweep_done) begin
      issued_d = 1'b0;
    end else if (sweep_st) begin
      issued_d = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aps_pkg::S_LOAD: if (accept && stat_i.load_last) state_d = aps_pkg::S_START;
      aps_pkg::S_START: state_d = aps_pkg::S_RMIN;
      aps_pkg::S_RMIN: if (stat_i.sweep_done) state_d = aps_pkg::S_RSUB;
      aps_pkg::S_RSUB: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.line_last ? aps_pkg::S_CMIN : aps_pkg::S_RMIN;
        end
      end
      aps_pkg::S_CMIN: if (stat_i.sweep_done) state_d = aps_pkg::S_CSUB;
      aps_pkg::S_CSUB: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.line_last ? aps_pkg::S_ZCNT : aps_pkg::S_CMIN;
        end
      end
      aps_pkg::S_ZCNT: if (stat_i.sweep_done) state_d = aps_pkg::S_BEST;
      aps_pkg::S_BEST: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.found ? aps_pkg::S_GFIND : aps_pkg::S_COVER;
        end
      end
      aps_pkg::S_GFIND: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.hit ? aps_pkg::S_GDEC : aps_pkg::S_BEST;
        end
      end
      aps_pkg::S_GDEC: if (stat_i.sweep_done) state_d = aps_pkg::S_BEST;
      aps_pkg::S_COVER: state_d = aps_pkg::S_CHECK;
      aps_pkg::S_CHECK: state_d = stat_i.all_cov ? aps_pkg::S_EMIT : aps_pkg::S_FIND;
      aps_pkg::S_FIND: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.hit ? aps_pkg::S_PRIME : aps_pkg::S_SMIN;
        end
      end
      aps_pkg::S_PRIME: state_d = stat_i.sir_hit ? aps_pkg::S_CHECK : aps_pkg::S_AUG;
      aps_pkg::S_AUG: if (!stat_i.aug_more) state_d = aps_pkg::S_COVER;
      aps_pkg::S_SMIN: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.any ? aps_pkg::S_SHIFT : aps_pkg::S_EMIT;
        end
      end
      aps_pkg::S_SHIFT: if (stat_i.sweep_done) state_d = aps_pkg::S_CHECK;
      aps_pkg::S_EMIT: state_d = aps_pkg::S_LOAD;
      default: state_d = aps_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aps_pkg::S_LOAD;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

endmodule

@@ design/aps_dp.sv @@
// Datapath of the assignment problem solver: cost memory, cell walker,
// star/prime/cover registers and result emitter. Depends on aps_pkg.
module aps_dp #(
  parameter int MAX_SIZE   = aps_pkg::MAX_SIZE_DEF,
  parameter int COST_WIDTH = aps_pkg::COST_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [aps_pkg::CFG_W-1:0]     cfg_wr_data_i,
  input  logic [COST_WIDTH-1:0]         cost_i,
  input  aps_pkg::dp_cmd_t              cmd_i,
  output aps_pkg::dp_stat_t             stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [aps_pkg::IDX_OUT_W-1:0] row_index_o,
  output logic [aps_pkg::IDX_OUT_W-1:0] assigned_column_o,
  output logic                          last_result_o
);

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int CW    = IW + 1;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int VW    = aps_pkg::CELL_W;

  // Size register and derived limits
  logic [aps_pkg::CFG_W-1:0] size_q;
  logic [6:0]                eff7;
  logic [CW-1:0]             n, nm1;
  logic [IW-1:0]             last_idx;
  logic [MAX_SIZE-1:0]       in_use;

  always_comb begin
    if (size_q == '0) begin
      eff7 = 7'd1;
    end else if ({1'b0, size_q} > 7'(MAX_SIZE)) begin
      eff7 = 7'(MAX_SIZE);
    end else begin
      eff7 = {1'b0, size_q};
    end
    n        = eff7[CW-1:0];
    nm1      = n - CW'(1);
    last_idx = nm1[IW-1:0];
    for (int k = 0; k < MAX_SIZE; k++) begin
      in_use[k] = CW'(k) < n;
    end
  end

  // Cost memory
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_q;
  logic          mem_we, sw_we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, sw_wdata;

  // Load position
  logic [IW-1:0] ld_i_q, ld_j_q;
  logic          load_last;

  // Walker
  logic                 sw_act_q, pv_q, plast_q, done_q;
  aps_pkg::dp_op_e      op_q;
  aps_pkg::sweep_kind_e kind_q, kind_d;
  logic [IW-1:0]        ia_q, ja_q, pi_q, pj_q, ia_st, ja_st;
  logic                 is_last, stop, is_sweep;

  // Algorithm registers
  logic [VW-1:0]   min_q;
  logic            any_q, found_q, hit_q;
  logic [IW-1:0]   best_q, gcol_q, hit_i_q, hit_j_q, line_q;
  logic [CW-1:0]   best_zc_q;
  logic [IW-1:0]   starcol_q [MAX_SIZE];
  logic [IW-1:0]   starrow_q [MAX_SIZE];
  logic [IW-1:0]   prime_q   [MAX_SIZE];
  logic [CW-1:0]   zc_q      [MAX_SIZE];
  logic [MAX_SIZE-1:0] sir_q, sic_q, pin_q, rowcov_q, colcov_q, active_q;
  logic [IW-1:0]   aug_r_q, aug_c_q, r2;
  logic [CW-1:0]   aug_cnt_q;
  logic            aug_chain;

  // Emitter
  logic          emit_busy_q, take;
  logic [IW-1:0] emit_row_q;
  logic          out_valid_q;

  // Cell checks at the compare stage
  logic          cell_zero, unc, both;
  logic [VW:0]   sum;

  assign load_last = (ld_i_q == last_idx) && (ld_j_q == last_idx);
  assign cell_zero = rd_q == '0;
  assign unc       = !rowcov_q[pi_q] && !colcov_q[pj_q];
  assign both      = rowcov_q[pi_q] && colcov_q[pj_q];
  assign sum       = {1'b0, rd_q} + {1'b0, min_q};
  assign r2        = starrow_q[aug_c_q];
  assign aug_chain = sic_q[aug_c_q] && (aug_cnt_q < n);

  // Sweep decode at launch
  always_comb begin
    is_sweep = 1'b1;
    kind_d   = aps_pkg::SK_ALL;
    ia_st    = '0;
    ja_st    = '0;
    case (cmd_i.op)
      aps_pkg::OP_ROW_MIN, aps_pkg::OP_ROW_SUB: begin kind_d = aps_pkg::SK_ROW; ia_st = line_q; end
      aps_pkg::OP_GFIND: begin kind_d = aps_pkg::SK_ROW; ia_st = best_q; end
      aps_pkg::OP_COL_MIN, aps_pkg::OP_COL_SUB: begin kind_d = aps_pkg::SK_COL; ja_st = line_q; end
      aps_pkg::OP_GDEC: begin kind_d = aps_pkg::SK_COL; ja_st = gcol_q; end
      aps_pkg::OP_BEST: kind_d = aps_pkg::SK_COL;
      aps_pkg::OP_ZCOUNT, aps_pkg::OP_FIND, aps_pkg::OP_SMIN, aps_pkg::OP_SHIFT: ;
      default: is_sweep = 1'b0;
    endcase
  end

  // Walk end and early stop
  always_comb begin
    case (kind_q)
      aps_pkg::SK_ROW: is_last = ja_q == last_idx;
      aps_pkg::SK_COL: is_last = ia_q == last_idx;
      default:         is_last = (ia_q == last_idx) && (ja_q == last_idx);
    endcase
    stop = pv_q && cell_zero &&
           (((op_q == aps_pkg::OP_FIND) && unc) ||
            ((op_q == aps_pkg::OP_GFIND) && !sic_q[pj_q]));
  end

  // Write-back of the compare stage
  always_comb begin
    sw_we    = 1'b0;
    sw_wdata = rd_q - min_q;
    if (pv_q) begin
      case (op_q)
        aps_pkg::OP_ROW_SUB, aps_pkg::OP_COL_SUB: sw_we = 1'b1;
        aps_pkg::OP_SHIFT: begin
          if (unc) begin
            sw_we = 1'b1;
          end else if (both) begin
            sw_we    = 1'b1;
            sw_wdata = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];
          end
        end
        default: ;
      endcase
    end
    mem_we = cmd_i.load_we || sw_we;
    waddr  = cmd_i.load_we ? {ld_i_q, ld_j_q} : {pi_q, pj_q};
    wdata  = cmd_i.load_we ? VW'(cost_i) : sw_wdata;
    raddr  = {ia_q, ja_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign take = emit_busy_q && (!out_valid_q || !out_stall_i);

  // Control and algorithm state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= aps_pkg::SIZE_RESET;
      ld_i_q      <= '0;
      ld_j_q      <= '0;
      sw_act_q    <= 1'b0;
      pv_q        <= 1'b0;
      plast_q     <= 1'b0;
      done_q      <= 1'b0;
      op_q        <= aps_pkg::OP_NONE;
      kind_q      <= aps_pkg::SK_ALL;
      ia_q        <= '0;
      ja_q        <= '0;
      pi_q        <= '0;
      pj_q        <= '0;
      min_q       <= '0;
      any_q       <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      best_q      <= '0;
      best_zc_q   <= '0;
      gcol_q      <= '0;
      hit_i_q     <= '0;
      hit_j_q     <= '0;
      line_q      <= '0;
      aug_r_q     <= '0;
      aug_c_q     <= '0;
      aug_cnt_q   <= '0;
      sir_q       <= '0;
      sic_q       <= '0;
      pin_q       <= '0;
      rowcov_q    <= '0;
      colcov_q    <= '0;
      active_q    <= '0;
      for (int k = 0; k < MAX_SIZE; k++) begin
        starcol_q[k] <= '0;
        starrow_q[k] <= '0;
        prime_q[k]   <= '0;
        zc_q[k]      <= '0;
      end
      emit_busy_q <= 1'b0;
      emit_row_q  <= '0;
      out_valid_q <= 1'b0;
      row_index_o <= '0;
      assigned_column_o <= '0;
      last_result_o     <= 1'b0;
    end else begin
      // configuration restarts the load
      if (cfg_wr_en_i) begin
        size_q <= cfg_wr_data_i;
        ld_i_q <= '0;
        ld_j_q <= '0;
      end else if (cmd_i.load_we) begin
        if (ld_j_q == last_idx) begin
          ld_j_q <= '0;
          ld_i_q <= load_last ? '0 : ld_i_q + IW'(1);
        end else begin
          ld_j_q <= ld_j_q + IW'(1);
        end
      end

      // issue stage: launch or advance the walk
      if (cmd_i.start && is_sweep) begin
        sw_act_q <= 1'b1;
        op_q     <= cmd_i.op;
        kind_q   <= kind_d;
        ia_q     <= ia_st;
        ja_q     <= ja_st;
        if (cmd_i.op == aps_pkg::OP_ROW_MIN || cmd_i.op == aps_pkg::OP_COL_MIN ||
            cmd_i.op == aps_pkg::OP_SMIN) begin
          any_q <= 1'b0;
        end
        if (cmd_i.op == aps_pkg::OP_FIND || cmd_i.op == aps_pkg::OP_GFIND) begin
          hit_q <= 1'b0;
        end
        if (cmd_i.op == aps_pkg::OP_BEST) begin
          found_q <= 1'b0;
        end
        if (cmd_i.op == aps_pkg::OP_ZCOUNT) begin
          active_q <= '0;
          for (int k = 0; k < MAX_SIZE; k++) begin
            zc_q[k] <= '0;
          end
        end
      end else if (sw_act_q && !stop) begin
        if (is_last) begin
          sw_act_q <= 1'b0;
        end else begin
          case (kind_q)
            aps_pkg::SK_ROW: ja_q <= ja_q + IW'(1);
            aps_pkg::SK_COL: ia_q <= ia_q + IW'(1);
            default: begin
              if (ja_q == last_idx) begin
                ja_q <= '0;
                ia_q <= ia_q + IW'(1);
              end else begin
                ja_q <= ja_q + IW'(1);
              end
            end
          endcase
        end
      end else if (stop) begin
        sw_act_q <= 1'b0;
      end

      pv_q    <= sw_act_q && !stop;
      plast_q <= is_last;
      pi_q    <= ia_q;
      pj_q    <= ja_q;
      done_q  <= pv_q && (plast_q || stop);

      // compare stage
      if (pv_q) begin
        case (op_q)
          aps_pkg::OP_ROW_MIN, aps_pkg::OP_COL_MIN: begin
            if (!any_q || rd_q < min_q) begin
              min_q <= rd_q;
              any_q <= 1'b1;
            end
          end
          aps_pkg::OP_SMIN: begin
            if (unc && (!any_q || rd_q < min_q)) begin
              min_q <= rd_q;
              any_q <= 1'b1;
            end
          end
          aps_pkg::OP_ZCOUNT: begin
            if (cell_zero) begin
              zc_q[pi_q]     <= zc_q[pi_q] + CW'(1);
              active_q[pi_q] <= 1'b1;
            end
          end
          aps_pkg::OP_BEST: begin
            if (active_q[pi_q] && (!found_q || zc_q[pi_q] < best_zc_q)) begin
              best_q    <= pi_q;
              best_zc_q <= zc_q[pi_q];
              found_q   <= 1'b1;
            end
          end
          aps_pkg::OP_GFIND: begin
            if (stop) begin
              hit_q             <= 1'b1;
              gcol_q            <= pj_q;
              starcol_q[best_q] <= pj_q;
              sir_q[best_q]     <= 1'b1;
              starrow_q[pj_q]   <= best_q;
              sic_q[pj_q]       <= 1'b1;
            end
          end
          aps_pkg::OP_GDEC: begin
            if (active_q[pi_q] && cell_zero) begin
              zc_q[pi_q] <= zc_q[pi_q] - CW'(1);
              if (zc_q[pi_q] == CW'(1)) begin
                active_q[pi_q] <= 1'b0;
              end
            end
          end
          aps_pkg::OP_FIND: begin
            if (stop) begin
              hit_q   <= 1'b1;
              hit_i_q <= pi_q;
              hit_j_q <= pj_q;
            end
          end
          default: ;
        endcase
      end

      // wrap-up of a finished walk
      if (done_q) begin
        if (op_q == aps_pkg::OP_ROW_SUB || op_q == aps_pkg::OP_COL_SUB) begin
          line_q <= (line_q == last_idx) ? '0 : line_q + IW'(1);
        end
        if (op_q == aps_pkg::OP_BEST && found_q) begin
          active_q[best_q] <= 1'b0;
        end
      end

      // operations issued without a cell walk
      if (cmd_i.start) begin
        case (cmd_i.op)
          aps_pkg::OP_START: begin
            sir_q  <= '0;
            sic_q  <= '0;
            line_q <= '0;
          end
          aps_pkg::OP_COVER: begin
            colcov_q <= sic_q;
            rowcov_q <= '0;
            pin_q    <= '0;
          end
          aps_pkg::OP_PRIME: begin
            prime_q[hit_i_q] <= hit_j_q;
            pin_q[hit_i_q]   <= 1'b1;
            if (sir_q[hit_i_q]) begin
              rowcov_q[hit_i_q]            <= 1'b1;
              colcov_q[starcol_q[hit_i_q]] <= 1'b0;
            end
            aug_r_q   <= hit_i_q;
            aug_c_q   <= hit_j_q;
            aug_cnt_q <= '0;
          end
          aps_pkg::OP_AUG: begin
            // drop the star on the chain, then star the prime
            if (aug_chain) begin
              sir_q[r2]      <= 1'b0;
              sic_q[aug_c_q] <= 1'b0;
              aug_cnt_q      <= aug_cnt_q + CW'(1);
              aug_r_q        <= r2;
              aug_c_q        <= prime_q[r2];
            end
            starcol_q[aug_r_q] <= aug_c_q;
            sir_q[aug_r_q]     <= 1'b1;
            starrow_q[aug_c_q] <= aug_r_q;
            sic_q[aug_c_q]     <= 1'b1;
          end
          aps_pkg::OP_EMIT: begin
            emit_busy_q <= 1'b1;
            emit_row_q  <= '0;
          end
          default: ;
        endcase
      end

      // result emitter with output register
      if (take) begin
        row_index_o       <= aps_pkg::IDX_OUT_W'(emit_row_q);
        assigned_column_o <= sir_q[emit_row_q] ?
                             aps_pkg::IDX_OUT_W'(starcol_q[emit_row_q]) : '0;
        last_result_o     <= emit_row_q == last_idx;
        if (emit_row_q == last_idx) begin
          emit_busy_q <= 1'b0;
        end else begin
          emit_row_q <= emit_row_q + IW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  always_comb begin
    stat_o.load_last  = load_last;
    stat_o.sweep_done = done_q;
    stat_o.line_last  = line_q == last_idx;
    stat_o.found      = found_q;
    stat_o.hit        = hit_q;
    stat_o.any        = any_q;
    stat_o.sir_hit    = sir_q[hit_i_q];
    stat_o.aug_more   = aug_chain && pin_q[r2];
    stat_o.all_cov    = &(colcov_q | ~in_use);
    stat_o.emit_busy  = emit_busy_q;
  end

endmodule

@@ design/assignment_problem_solver_core.sv @@
// Assignment problem solver (Hungarian method, Munkres variant). Costs arrive one
// word per cycle while the input is not stalled, row-major, N*N words per matrix,
// N from the size register (0 acts as 1, values above MAX_SIZE as MAX_SIZE).
// Writing the size restarts the load. On the last word the block stalls its input
// and solves: row then column reduction, greedy starring (a zero count over all
// cells, then for each starred row a pick of the row with fewest zeros, a search
// for its zero in an unstarred column and a decrement of the zero counts in that
// column), then Munkres rounds of a zero search, a minimum search and shift, and
// augmenting chains. Every cell visit goes through the single read port of the
// cost memory, one cell per cycle. N result words (row, assigned column, last
// flag) then leave through an output register; loading of the next matrix overlaps
// their delivery, but its last word is held until the last result of the previous
// matrix has entered the output register. No clearing pass is needed after reset.
module assignment_problem_solver_core #(
  parameter int MAX_SIZE   = aps_pkg::MAX_SIZE_DEF,
  parameter int COST_WIDTH = aps_pkg::COST_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [aps_pkg::CFG_W-1:0]     cfg_wr_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COST_WIDTH-1:0]         cost_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aps_pkg::IDX_OUT_W-1:0] row_index_o,
  output logic [aps_pkg::IDX_OUT_W-1:0] assigned_column_o,
  output logic                          last_result_o
);

  aps_pkg::dp_cmd_t  cmd;
  aps_pkg::dp_stat_t stat;

  aps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  aps_dp #(
    .MAX_SIZE   (MAX_SIZE),
    .COST_WIDTH (COST_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .cost_i            (cost_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .row_index_o       (row_index_o),
    .assigned_column_o (assigned_column_o),
    .last_result_o     (last_result_o)
  );

endmodule

@@ design/aps_checker.sv @@
// Port-level checks of the assignment problem solver, bound to the top level.
// Depends on aps_pkg for field widths.
module aps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [aps_pkg::IDX_OUT_W-1:0] row_index_o,
  input logic [aps_pkg::IDX_OUT_W-1:0] assigned_column_o,
  input logic                          last_result_o
);

  // hold a stalled result word
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(row_index_o) && $stable(assigned_column_o) && $stable(last_result_o))
    else $error("stalled result word changed");

  // nothing follows the last row of a matrix until the next solve
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_result_o |=> !out_valid_o)
    else $error("result after last row");

  // a result burst starts only after a solve held the input
  a_burst_after_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 2))
    else $error("results without a solve");

endmodule

bind assignment_problem_solver_core aps_checker u_aps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .row_index_o       (row_index_o),
  .assigned_column_o (assigned_column_o),
  .last_result_o     (last_result_o)
);
